FILE: hw/rtl/json_string_unescape_defines.svh
// Assertion macros shared by the JSON string unescaper modules.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/jsu_pkg.sv
// Types, constants and helpers for the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_CLOSED = 3'd1,
        KIND_BADESC = 3'd2,
        KIND_UNTERM = 3'd3,
        KIND_NOOPEN = 3'd4
    } kind_t;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK6 = 8'h3F;
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 3;

    // One queue entry: all results caused by one input item.
    typedef struct packed {
        logic [1:0] cnt;     // number of results, 1 to 3
        kind_t      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } cmd_t;

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/json_string_unescape.sv
// Top level of the JSON string unescaper.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------
//   input    | push / full      | in_byte
//   result   | pop / empty      | out_byte, kind, last_of_item
//
// One text byte can be taken every cycle unless the queue is full; the
// front end decides its 0 to 3 results in the cycle it is accepted and
// queues them as one command. The back end emits one result per cycle
// while pop is high, so a \u escape giving three bytes holds the output
// while the 4-entry queue absorbs input.
// Reset (rst_n low) empties queue and output stage and returns to idle.
// full follows the queue only; empty follows the output register only.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       last_of_item
);

    logic q_full, q_push, q_empty, q_pop;
    cmd_t q_cmd, q_head;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_byte (in_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    jsu_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .kind         (kind),
        .last_of_item (last_of_item)
    );

endmodule

FILE: hw/rtl/jsu_front.sv
// Front end: takes text bytes, tracks string state, builds result commands.
`include "json_string_unescape_defines.svh"

module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [11:0] cp_reg, cp_next;

    logic        accept;
    logic [4:0]  hex;
    logic [15:0] cp_full;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign hex     = hex_decode(in_byte);
    assign cp_full = {cp_reg, hex[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 12'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        q_push       = 1'b0;
        q_cmd        = '{cnt: 2'd1, kind: KIND_DATA, b0: 8'd0, b1: 8'd0, b2: 8'd0};
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == CH_QUOTE)
                        phase_next = PH_BODY;
                    else
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_NOOPEN;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_CLOSED;
                        phase_next = PH_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                        phase_next = PH_ESC;
                    else if (in_byte == CH_END)
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_UNTERM;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        q_push   = 1'b1;
                        q_cmd.b0 = in_byte;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    q_push     = 1'b1;
                    case (in_byte)
                        CH_N:      q_cmd.b0 = CH_LF;
                        CH_R:      q_cmd.b0 = CH_CR;
                        CH_T:      q_cmd.b0 = CH_TAB;
                        CH_B:      q_cmd.b0 = CH_BS;
                        CH_F:      q_cmd.b0 = CH_FF;
                        CH_QUOTE,
                        CH_BSLASH,
                        CH_SLASH:  q_cmd.b0 = in_byte;
                        CH_U:
                        begin
                            q_push       = 1'b0;
                            phase_next   = PH_HEX;
                            hex_cnt_next = 2'd0;
                            cp_next      = 12'd0;
                        end
                        default:
                        begin
                            q_cmd.kind = KIND_BADESC;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                PH_HEX:
                begin
                    if (!hex[4])
                    begin
                        q_push       = 1'b1;
                        q_cmd.kind   = KIND_BADESC;
                        phase_next   = PH_IDLE;
                        hex_cnt_next = 2'd0;
                        cp_next      = 12'd0;
                    end
                    else if (hex_cnt_reg == 2'd3)
                    begin
                        q_push       = 1'b1;
                        phase_next   = PH_BODY;
                        hex_cnt_next = 2'd0;
                        cp_next      = 12'd0;
                        if (cp_full < UTF8_LIM1)
                            q_cmd.b0 = cp_full[7:0];
                        else if (cp_full < UTF8_LIM2)
                        begin
                            q_cmd.cnt = 2'd2;
                            q_cmd.b0  = UTF8_LEAD2 | {3'd0, cp_full[10:6]};
                            q_cmd.b1  = UTF8_CONT | (cp_full[7:0] & UTF8_MASK6);
                        end
                        else
                        begin
                            q_cmd.cnt = 2'd3;
                            q_cmd.b0  = UTF8_LEAD3 | {4'd0, cp_full[15:12]};
                            q_cmd.b1  = UTF8_CONT | (cp_full[13:6] & UTF8_MASK6);
                            q_cmd.b2  = UTF8_CONT | (cp_full[7:0] & UTF8_MASK6);
                        end
                    end
                    else
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        cp_next      = cp_full[11:0];
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    `JSU_ASSERT_IMPL(a_idle_clear, clk, rst_n, phase_reg == PH_IDLE,
        hex_cnt_reg == 2'd0 && cp_reg == 12'd0, "hex state not cleared while idle")
    `JSU_ASSERT_IMPL(a_hex_only, clk, rst_n, hex_cnt_reg != 2'd0,
        phase_reg == PH_HEX, "hex digit count outside a unicode escape")

endmodule

FILE: hw/rtl/jsu_cmd_queue.sv
// Short command queue between the front end and the result emitter.
module jsu_cmd_queue
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/jsu_back.sv
// Back end: expands queued commands into single result items.
`include "json_string_unescape_defines.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       last_of_item
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    kind_t      kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;

    logic       taken, load, is_last;
    logic [7:0] sel_byte;

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign kind         = kind_reg;
    assign last_of_item = last_reg;

    assign taken   = pop && out_valid_reg;
    assign load    = !q_empty && (!out_valid_reg || taken);
    assign is_last = (idx_reg == q_head.cnt - 2'd1);
    assign q_pop   = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = q_head.b0;
            2'd1:    sel_byte = q_head.b1;
            2'd2:    sel_byte = q_head.b2;
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            byte_next      = sel_byte;
            kind_next      = q_head.kind;
            last_next      = is_last;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (taken)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    `JSU_ASSERT_IMPL(a_ctrl_zero, clk, rst_n, out_valid_reg && kind_reg != KIND_DATA,
        byte_reg == 8'd0 && last_reg, "control item must be a lone zero byte")
    `JSU_ASSERT_IMPL(a_idx_held, clk, rst_n, idx_reg != 2'd0,
        !q_empty && idx_reg < q_head.cnt, "partial command lost from queue head")
    `JSU_ASSERT_NEXT(a_split_tail, clk, rst_n, load && !is_last,
        out_valid_reg && !last_reg, "multi-byte command emitted out of order")

endmodule

FILE: tb/tb_json_string_unescape.sv
// Testbench for json_string_unescape: directed and random JSON strings, checked per result.
module tb_json_string_unescape
    import jsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int STIM_TARGET   = 250;   // directed bytes plus random ones, about 250 in all
    localparam int CALM_FROM     = 210;   // no idling on either side past this point
    localparam int DRAIN_CYCLES  = 10;

    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_G = 8'h67;

    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } unesc_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last_of_item;

    // predictor state
    phase_t      unesc_phase = PH_IDLE;
    logic [1:0]  hex_count = 2'd0;
    logic [15:0] code_acc = 16'h0000;

    unesc_result_t pending_results[$];
    int  fail_count = 0;
    int  bytes_sent = 0;
    int  cycle_count = 0;
    int  pop_stall_left = 0;
    bit  idling_on = 1'b1;

    logic [7:0] esc_letters[8] = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CH_BSLASH, CH_SLASH};

    json_string_unescape DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .kind         (kind),
        .last_of_item (last_of_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        foreach (esc_letters[i])
        begin
            if (esc_letters[i] == c)
            begin
                return 1'b1;
            end
        end
        return c == CH_U;
    endfunction

    function automatic void return_to_idle();
        unesc_phase = PH_IDLE;
        hex_count   = 2'd0;
        code_acc    = 16'h0000;
    endfunction

    // Advance the predictor by one accepted byte and queue the results it causes.
    task automatic predict_unescape(input logic [7:0] c);
        unesc_result_t res[$];
        logic [4:0]    digit;
        logic [15:0]   cp;
        case (unesc_phase)
            PH_IDLE:
            begin
                if (c == CH_QUOTE)
                begin
                    unesc_phase = PH_BODY;
                end
                else
                begin
                    res.push_back('{8'h00, KIND_NOOPEN, 1'b0});
                    return_to_idle();
                end
            end
            PH_BODY:
            begin
                if (c == CH_QUOTE)
                begin
                    res.push_back('{8'h00, KIND_CLOSED, 1'b0});
                    return_to_idle();
                end
                else if (c == CH_BSLASH)
                begin
                    unesc_phase = PH_ESC;
                end
                else if (c == CH_END)
                begin
                    res.push_back('{8'h00, KIND_UNTERM, 1'b0});
                    return_to_idle();
                end
                else
                begin
                    res.push_back('{c, KIND_DATA, 1'b0});
                end
            end
            PH_ESC:
            begin
                unesc_phase = PH_BODY;
                case (c)
                    CH_N: res.push_back('{CH_LF, KIND_DATA, 1'b0});
                    CH_R: res.push_back('{CH_CR, KIND_DATA, 1'b0});
                    CH_T: res.push_back('{CH_TAB, KIND_DATA, 1'b0});
                    CH_B: res.push_back('{CH_BS, KIND_DATA, 1'b0});
                    CH_F: res.push_back('{CH_FF, KIND_DATA, 1'b0});
                    CH_QUOTE, CH_BSLASH, CH_SLASH: res.push_back('{c, KIND_DATA, 1'b0});
                    CH_U:
                    begin
                        unesc_phase = PH_HEX;
                        hex_count   = 2'd0;
                        code_acc    = 16'h0000;
                    end
                    default:
                    begin
                        res.push_back('{8'h00, KIND_BADESC, 1'b0});
                        return_to_idle();
                    end
                endcase
            end
            default:
            begin
                digit = hex_digit_value(c);
                if (!digit[4])
                begin
                    res.push_back('{8'h00, KIND_BADESC, 1'b0});
                    return_to_idle();
                end
                else
                begin
                    cp = {code_acc[11:0], digit[3:0]};
                    code_acc = cp;
                    if (hex_count == 2'd3)
                    begin
                        if (cp < UTF8_LIM1)
                        begin
                            res.push_back('{cp[7:0], KIND_DATA, 1'b0});
                        end
                        else if (cp < UTF8_LIM2)
                        begin
                            res.push_back('{UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA, 1'b0});
                            res.push_back('{UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA, 1'b0});
                        end
                        else
                        begin
                            res.push_back('{UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA, 1'b0});
                            res.push_back('{UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA, 1'b0});
                            res.push_back('{UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA, 1'b0});
                        end
                        unesc_phase = PH_BODY;
                        hex_count   = 2'd0;
                        code_acc    = 16'h0000;
                    end
                    else
                    begin
                        hex_count = hex_count + 2'd1;
                    end
                end
            end
        endcase
        if (res.size() > 0)
        begin
            res[res.size() - 1].last = 1'b1;
        end
        foreach (res[i])
        begin
            pending_results.push_back(res[i]);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] c);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        push    = 1'b1;
        in_byte = c;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predict_unescape(c);
        bytes_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    // case_mask bit i picks upper case for hex digit i (most significant first = bit 3)
    task automatic send_unicode_escape(input logic [15:0] cp, input logic [3:0] case_mask);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            send_byte(hex_char(cp[i*4 +: 4], case_mask[i]));
        end
    endtask

    task automatic send_random_token();
        logic [7:0]  c;
        logic [15:0] cp;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            c = 8'($urandom_range(1, 255));
            while (c == CH_QUOTE || c == CH_BSLASH)
            begin
                c = 8'($urandom_range(1, 255));
            end
            send_byte(c);
        end
        else if (sel < 7)
        begin
            send_byte(CH_BSLASH);
            send_byte(esc_letters[$urandom_range(0, 7)]);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            send_unicode_escape(cp, 4'($urandom_range(0, 15)));
        end
    endtask

    // One random string; a broken one ends in a random fault or is a lone byte with no quote.
    task automatic send_random_string(input bit well_formed);
        logic [7:0] c;
        int         n_tokens;
        int         fault;
        fault = $urandom_range(0, 4);
        if (!well_formed && fault == 0)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE)
            begin
                c = CH_END;
            end
            send_byte(c);
            return;
        end
        n_tokens = $urandom_range(0, 8);
        send_byte(CH_QUOTE);
        repeat (n_tokens) send_random_token();
        if (well_formed)
        begin
            send_byte(CH_QUOTE);
            return;
        end
        case (fault)
            1: send_byte(CH_END);
            2:
            begin
                send_byte(CH_BSLASH);
                send_byte(CH_END);
            end
            3:
            begin
                send_byte(CH_BSLASH);
                c = 8'($urandom_range(0, 255));
                while (is_escape_letter(c))
                begin
                    c = 8'($urandom_range(0, 255));
                end
                send_byte(c);
            end
            default:
            begin
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15)),
                                                               1'($urandom_range(0, 1))));
                c = 8'($urandom_range(0, 255));
                while (hex_digit_value(c) != 5'd0)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                send_byte(c);
            end
        endcase
    endtask

    task automatic test_missing_quote();
        send_byte(CH_END);
        send_byte(8'hFF);
    endtask

    task automatic test_plain_string();
        send_byte(CH_QUOTE);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
    endtask

    // \u0000 gives a zero data byte; \ufFfF mixes case and needs three bytes
    task automatic test_unicode_and_unterminated();
        send_byte(CH_QUOTE);
        send_unicode_escape(16'h0000, 4'b0000);
        send_unicode_escape(16'hFFFF, 4'b0101);
        send_byte(CH_END);
    endtask

    task automatic test_escape_errors();
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_END);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_LOWER_X);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte(8'h31);
        send_byte(CH_LOWER_G);
    endtask

    task automatic test_random_strings();
        while (bytes_sent < STIM_TARGET)
        begin
            if (bytes_sent >= CALM_FROM)
            begin
                idling_on = 1'b0;
            end
            send_random_string($urandom_range(0, 4) != 0);
        end
        idling_on = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_missing_quote();
        test_plain_string();
        test_unicode_and_unterminated();
        test_escape_errors();
        test_random_strings();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_json_string_unescape passed");
        end
        else
        begin
            $display("tb_json_string_unescape failed");
        end
        $finish;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (pop_stall_left != 0)
        begin
            pop_stall_left <= pop_stall_left - 1;
            pop <= 1'b0;
        end
        else if (rst_n && idling_on && $urandom_range(0, 7) == 0)
        begin
            pop_stall_left <= $urandom_range(0, 14);
            pop <= 1'b0;
        end
        else
        begin
            pop <= rst_n;
        end
    end

    always @(posedge clk)
    begin : check_results
        unesc_result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: out_byte %02h kind %0d last_of_item %0d",
                       out_byte, kind, last_of_item);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_byte !== exp_r.data)
                begin
                    $error("out_byte: expected %02h, got %02h", exp_r.data, out_byte);
                    fail_count++;
                end
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                    fail_count++;
                end
                if (last_of_item !== exp_r.last)
                begin
                    $error("last_of_item: expected %0d, got %0d", exp_r.last, last_of_item);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_json_string_unescape failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_cmd_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape.sv
tb/tb_json_string_unescape.sv
